FILE: src/mie_pkg.sv
package mie_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int VALUE_WIDTH = 63;
    localparam int CNT_WIDTH = $clog2(DATA_WIDTH + 1);

    typedef struct packed {
        logic                         func;
        logic signed [DATA_WIDTH-1:0] operand;
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] modulus;
    } t_in_beat;

    typedef struct packed {
        logic                   exists;
        logic [VALUE_WIDTH-1:0] value;
    } t_out_beat;

    // requests to the shared divider
    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] num;
        logic [DATA_WIDTH-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_A_W,
        S_EUC,
        S_EUC_W,
        S_EUC_MUL,
        S_FIX,
        S_RED_D,
        S_RED_D_W,
        S_MUL,
        S_DONE
    } t_state;

endpackage

FILE: src/mie_div.sv
module mie_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mie_pkg::t_div_req i_req,
    output mie_pkg::t_div_rsp o_rsp
);

    logic [mie_pkg::DATA_WIDTH-1:0] r_quo, n_quo;
    logic [mie_pkg::DATA_WIDTH-1:0] r_rem, n_rem;
    logic [mie_pkg::DATA_WIDTH-1:0] r_den, n_den;
    logic [mie_pkg::CNT_WIDTH-1:0]  r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [mie_pkg::DATA_WIDTH:0]   w_trial;

    // one restoring step a cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[mie_pkg::DATA_WIDTH-1]};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = mie_pkg::CNT_WIDTH'(mie_pkg::DATA_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                w_trial = w_trial - {1'b0, r_den};
                n_quo = {r_quo[mie_pkg::DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_quo = {r_quo[mie_pkg::DATA_WIDTH-2:0], 1'b0};
            end
            n_rem = w_trial[mie_pkg::DATA_WIDTH-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == mie_pkg::CNT_WIDTH'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("start not taken");
    a_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0) else $error("count left over");

endmodule

FILE: src/modular_inverse_extgcd.sv
// flow: a modulus below two goes straight to the done state; otherwise the operand is reduced,
// then euclid steps run, plus a reduction of the dividend and a modular product in divide mode
// each euclid step is one restoring division and one shift-add product
// throughput: one beat at a time; ready only when idle and no result is waiting
// reset: synchronous active-low, clears the sequencer and the output valid
module modular_inverse_extgcd (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mie_pkg::t_in_beat    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mie_pkg::t_out_beat   o_data
);

    localparam int W = mie_pkg::DATA_WIDTH;

    mie_pkg::t_state r_state, n_state;
    mie_pkg::t_div_req w_req;
    mie_pkg::t_div_rsp w_rsp;

    logic [W-1:0] r_m, n_m;
    logic [W-1:0] r_r0, n_r0, r_r1, n_r1;
    logic [W-1:0] r_s0, n_s0, r_s1, n_s1;
    logic [W-1:0] r_q, n_q;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_mb, n_mb;
    logic [W-1:0] r_dmag, n_dmag;
    logic         r_dneg, n_dneg;
    logic         r_fneg, n_fneg;
    logic         r_div, n_div;
    logic [mie_pkg::CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic         r_ovalid, n_ovalid;
    logic         r_oex, n_oex;
    logic [mie_pkg::VALUE_WIDTH-1:0] r_oval, n_oval;

    logic [W-1:0] w_amag, w_dmag, w_mmag;
    logic [W:0]   w_sum;
    logic [W:0]   w_dbl;
    logic [W-1:0] w_red;

    always_comb begin
        w_amag = i_data.operand[W-1] ? (W'(0) - i_data.operand) : i_data.operand;
        w_dmag = i_data.dividend[W-1] ? (W'(0) - i_data.dividend) : i_data.dividend;
        w_mmag = i_data.modulus;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mie_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    if (w_mmag[W-1] || w_mmag < W'(2)) n_state = mie_pkg::S_DONE;
                    else n_state = mie_pkg::S_RED_A_W;
                end
            end
            mie_pkg::S_RED_A:   n_state = mie_pkg::S_RED_A_W;
            mie_pkg::S_RED_A_W: if (w_rsp.done) n_state = mie_pkg::S_EUC;
            mie_pkg::S_EUC:     n_state = (r_r1 == '0) ? mie_pkg::S_FIX : mie_pkg::S_EUC_W;
            mie_pkg::S_EUC_W:   if (w_rsp.done) n_state = mie_pkg::S_EUC_MUL;
            mie_pkg::S_EUC_MUL: if (r_cnt == '0) n_state = mie_pkg::S_EUC;
            mie_pkg::S_FIX: begin
                if (r_r0 != W'(1)) n_state = mie_pkg::S_DONE;
                else if (r_div) n_state = mie_pkg::S_RED_D;
                else n_state = mie_pkg::S_DONE;
            end
            mie_pkg::S_RED_D:   n_state = mie_pkg::S_RED_D_W;
            mie_pkg::S_RED_D_W: if (w_rsp.done) n_state = mie_pkg::S_MUL;
            mie_pkg::S_MUL:     if (r_cnt == '0) n_state = mie_pkg::S_DONE;
            mie_pkg::S_DONE:    if (!r_ovalid || i_ready) n_state = mie_pkg::S_IDLE;
            default:            n_state = mie_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_m = r_m; n_r0 = r_r0; n_r1 = r_r1; n_s0 = r_s0; n_s1 = r_s1;
        n_q = r_q; n_acc = r_acc; n_mb = r_mb; n_dmag = r_dmag; n_dneg = r_dneg;
        n_fneg = r_fneg; n_div = r_div; n_cnt = r_cnt;
        n_oex = r_oex; n_oval = r_oval;
        n_ovalid = r_ovalid && !i_ready;
        w_req = '0;
        w_sum = '0;
        w_dbl = '0;
        w_red = '0;
        unique case (r_state)
            mie_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_m = w_mmag; n_div = i_data.func;
                    n_fneg = i_data.operand[W-1];
                    n_dneg = i_data.dividend[W-1]; n_dmag = w_dmag;
                    n_oex = 1'b0; n_oval = '0;
                    w_req.start = 1'b1; w_req.num = w_amag; w_req.den = w_mmag;
                end
            end
            mie_pkg::S_RED_A: begin
                w_req.start = 1'b1; w_req.num = r_r0; w_req.den = r_m;
            end
            mie_pkg::S_RED_A_W: begin
                if (w_rsp.done) begin
                    n_r0 = (r_fneg && w_rsp.rem != '0) ? r_m - w_rsp.rem : w_rsp.rem;
                    n_r1 = r_m; n_s0 = W'(1); n_s1 = '0;
                end
            end
            mie_pkg::S_EUC: begin
                if (r_r1 != '0) begin
                    w_req.start = 1'b1; w_req.num = r_r0; w_req.den = r_r1;
                end
            end
            mie_pkg::S_EUC_W: begin
                if (w_rsp.done) begin
                    n_r0 = r_r1; n_r1 = w_rsp.rem;
                    n_q = w_rsp.quo; n_acc = '0; n_mb = r_s1;
                    n_cnt = mie_pkg::CNT_WIDTH'(W);
                end
            end
            mie_pkg::S_EUC_MUL: begin
                // shift-add q * s1, wrapping at W bits
                if (r_cnt != '0) begin
                    n_acc = r_acc + (r_q[0] ? r_mb : '0);
                    n_q = r_q >> 1; n_mb = r_mb << 1;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_s1 = r_s0 - r_acc; n_s0 = r_s1;
                end
            end
            mie_pkg::S_FIX: begin
                // s0 lies within +-m, one correction brings it into range
                w_red = r_s0[W-1] ? r_s0 + r_m : r_s0;
                n_s0 = w_red;
                if (r_r0 == W'(1) && !r_div) begin
                    n_oex = 1'b1; n_oval = w_red[mie_pkg::VALUE_WIDTH-1:0];
                end
            end
            mie_pkg::S_RED_D: begin
                w_req.start = 1'b1; w_req.num = r_dmag; w_req.den = r_m;
            end
            mie_pkg::S_RED_D_W: begin
                if (w_rsp.done) begin
                    n_mb = (r_dneg && w_rsp.rem != '0) ? r_m - w_rsp.rem : w_rsp.rem;
                    n_acc = '0; n_q = r_s0; n_cnt = mie_pkg::CNT_WIDTH'(W);
                end
            end
            mie_pkg::S_MUL: begin
                // msb-first shift-add modular product
                if (r_cnt != '0) begin
                    w_dbl = {r_acc, 1'b0};
                    if (w_dbl >= {1'b0, r_m}) w_dbl = w_dbl - {1'b0, r_m};
                    w_sum = w_dbl + (r_q[W-1] ? {1'b0, r_mb} : '0);
                    if (w_sum >= {1'b0, r_m}) w_sum = w_sum - {1'b0, r_m};
                    n_acc = w_sum[W-1:0];
                    n_q = r_q << 1;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_oex = 1'b1; n_oval = r_acc[mie_pkg::VALUE_WIDTH-1:0];
                end
            end
            mie_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mie_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
        r_m <= n_m; r_r0 <= n_r0; r_r1 <= n_r1; r_s0 <= n_s0; r_s1 <= n_s1;
        r_q <= n_q; r_acc <= n_acc; r_mb <= n_mb; r_dmag <= n_dmag;
        r_dneg <= n_dneg; r_fneg <= n_fneg; r_div <= n_div;
        r_oex <= n_oex; r_oval <= n_oval;
    end

    mie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_ready = (r_state == mie_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data.exists = r_oex;
    assign o_data.value  = r_oval;

    a_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.exists) |-> o_data.value == '0) else $error("stray value");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.exists) |-> {1'b0, o_data.value} < r_m) else $error("out of range");

endmodule
